FILE: src/secd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// secd_pkg
// Shared types and constants of the sampled-eviction cache directory.
// ----------------------------------------------------------------------------
package secd_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP   = 2'd0,
      OP_FETCH    = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_INVAL    = 2'd3
   } opcode_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOVICTIM = 2'd1;
   localparam logic [1:0] ST_ABSENT   = 2'd2;

   localparam logic [1:0] MODE_LRU = 2'd0;
   localparam logic [1:0] MODE_LFU = 2'd1;

   localparam logic [2:0] REG_ENTRIES = 3'd0;
   localparam logic [2:0] REG_POLICY  = 3'd1;
   localparam logic [2:0] REG_SAMPLES = 3'd2;
   localparam logic [2:0] REG_AGING   = 3'd3;
   localparam logic [2:0] REG_ASYNC   = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] tensor_key;
      logic [63:0] tensor_bytes;
      logic [31:0] row_count;
      logic [31:0] col_count;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       hit;
      logic [7:0] slot;
      logic       ready_res;
      logic       evicted;
      logic [8:0] pending_transfers;
   } rsp_type;

   typedef struct packed {
      logic [8:0]  entries_in_use;
      logic [1:0]  policy_mode;
      logic [6:0]  sample_count;
      logic [31:0] aging_period;
      logic        async_enable;
   } cfg_type;

   typedef enum logic [4:0] {
      S_IDLE, S_AGE_CHK, S_AGE_DIV, S_AGE_RD, S_AGE_WR, S_SCAN_RD, S_SCAN,
      S_DECIDE, S_DROP_SCAN_RD, S_DROP_SCAN, S_SAMP_RNG, S_SAMP_RD,
      S_SAMP_SCORE, S_DIV, S_SAMP_CMP, S_VICTIM, S_FILL, S_TOUCH_RD,
      S_TOUCH_WR, S_RESP
   } state_type;

endpackage
`default_nettype wire

FILE: src/secd_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// secd_divider
// Radix-2 restoring divider, 64-bit dividend by 33-bit divisor, one bit a cycle,
// giving both quotient and remainder.
// ----------------------------------------------------------------------------
module secd_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [32:0] divisor,
   output logic             done,
   output logic [63:0]      quotient,
   output logic [32:0]      remainder
);
   logic [63:0] quot_ff, quot_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], quot_ff[63]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff[32:0];
endmodule
`default_nettype wire

FILE: src/secd_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// secd_csr
// APB-style configuration registers of the directory.
// ----------------------------------------------------------------------------
module secd_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output secd_pkg::cfg_type cfg
);
   import secd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign wr = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (paddr[4:2])
            REG_ENTRIES: cfg_in.entries_in_use = pwdata[8:0];
            REG_POLICY:  cfg_in.policy_mode    = pwdata[1:0];
            REG_SAMPLES: cfg_in.sample_count   = pwdata[6:0];
            REG_AGING:   cfg_in.aging_period   = pwdata;
            REG_ASYNC:   cfg_in.async_enable   = pwdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entries_in_use <= 9'd256;
         cfg_ff.policy_mode    <= 2'd2;
         cfg_ff.sample_count   <= 7'd16;
         cfg_ff.aging_period   <= 32'd65536;
         cfg_ff.async_enable   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_ENTRIES: prdata = {23'd0, cfg_ff.entries_in_use};
         REG_POLICY:  prdata = {30'd0, cfg_ff.policy_mode};
         REG_SAMPLES: prdata = {25'd0, cfg_ff.sample_count};
         REG_AGING:   prdata = cfg_ff.aging_period;
         REG_ASYNC:   prdata = {31'd0, cfg_ff.async_enable};
         default:     prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;
endmodule
`default_nettype wire

FILE: src/sampled_eviction_cache_directory.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sampled_eviction_cache_directory
// Fully associative tensor directory with sampled LRU/LFU/hybrid eviction.
// Each request scans the slots; a fetch miss with async off scans twice. A lookup
// adds an aging check in the serial divider when aging is on, and halves the
// frequency of each slot below high water when aging runs. Each eviction sample
// reduces the generator value modulo the active slot count in the divider, and in
// hybrid mode divides for the score too. One request at a time: busy is high from
// acceptance until the result strobe. Reset is synchronous; no sweep.
// ----------------------------------------------------------------------------
module sampled_eviction_cache_directory #(
   parameter int SLOTS       = 256,
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire secd_pkg::req_type req_data,
   output logic                   rsp_valid,
   output secd_pkg::rsp_type      rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [4:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import secd_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = IW + 1;
   localparam int SW = $clog2(MAX_SAMPLES + 1);

   // Entry memory: key, size, rows, cols, stamp, frequency.
   typedef struct packed {
      logic [63:0] key;
      logic [63:0] size;
      logic [31:0] rows;
      logic [31:0] cols;
      logic [63:0] stamp;
      logic [31:0] freq;
   } entry_type;

   cfg_type cfg;

   secd_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .pready(csr_pready), .cfg(cfg)
   );

   entry_type mem [SLOTS];
   entry_type rd_data;
   logic [IW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   entry_type     wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

   logic [SLOTS-1:0] valid_ff, valid_in, fly_ff, fly_in;
   logic [63:0] gstamp_ff, gstamp_in, ltotal_ff, ltotal_in;
   logic [CW-1:0] hw_ff, hw_in;
   logic [8:0] pend_ff, pend_in;
   state_type st_ff, st_in;
   req_type req_ff, req_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [IW-1:0] match_ff, match_in, empty_ff, empty_in, victim_ff, victim_in;
   logic match_v_ff, match_v_in, empty_v_ff, empty_v_in, found_ff, found_in;
   logic key_v_ff, key_v_in;        // key-only match, for the drop path
   logic [IW-1:0] keym_ff, keym_in;
   logic [63:0] best_ff, best_in, score_ff, score_in;
   logic [31:0] rng_ff, rng_in;
   logic [SW-1:0] samp_ff, samp_in;
   logic [CW-1:0] n_act;
   logic [SW-1:0] n_samp;
   logic [31:0] rng_nx;
   logic [IW-1:0] rng_idx;
   logic flight_ff, flight_in, evict_ff, evict_in;
   rsp_type rsp_ff, rsp_in;
   logic rspv_ff, rspv_in;
   logic div_start, div_done;
   logic [63:0] div_q, div_a;
   logic [32:0] div_b, div_r;
   logic key_eq, size_eq, dims_bad;
   logic [IW-1:0] sidx_ff, sidx_in;   // sampled slot, generator value modulo n
   logic [IW-1:0] scan_idx;

   secd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   assign n_act = (cfg.entries_in_use == 9'd0) ? CW'(1) :
                  ({23'd0, cfg.entries_in_use} > 32'(SLOTS)) ? CW'(SLOTS) :
                  CW'(cfg.entries_in_use);
   assign n_samp = ({25'd0, cfg.sample_count} > 32'(MAX_SAMPLES)) ? SW'(MAX_SAMPLES) :
                   SW'(cfg.sample_count);
   assign busy = (st_ff != S_IDLE);
   assign scan_idx = idx_ff[IW-1:0];
   assign key_eq  = (rd_data.key == req_ff.tensor_key);
   assign size_eq = (rd_data.size == req_ff.tensor_bytes);
   assign dims_bad = (req_ff.row_count != 32'd0) && (req_ff.col_count != 32'd0) &&
                     ((rd_data.rows != req_ff.row_count) || (rd_data.cols != req_ff.col_count));

   always_comb begin
      rng_nx = rng_ff ^ (rng_ff << 13);
      rng_nx = rng_nx ^ (rng_nx >> 17);
      rng_nx = rng_nx ^ (rng_nx << 5);
   end
   assign rng_idx = sidx_ff;

   always_comb begin
      st_in = st_ff; req_in = req_ff; idx_in = idx_ff;
      valid_in = valid_ff; fly_in = fly_ff; gstamp_in = gstamp_ff;
      ltotal_in = ltotal_ff; hw_in = hw_ff; pend_in = pend_ff;
      match_in = match_ff; match_v_in = match_v_ff; empty_in = empty_ff;
      empty_v_in = empty_v_ff; found_in = found_ff; victim_in = victim_ff;
      key_v_in = key_v_ff; keym_in = keym_ff; best_in = best_ff;
      score_in = score_ff; rng_in = rng_ff; samp_in = samp_ff;
      flight_in = flight_ff; evict_in = evict_ff; sidx_in = sidx_ff;
      rsp_in = rsp_ff; rspv_in = 1'b0;
      rd_addr = scan_idx; wr_en = 1'b0; wr_addr = scan_idx; wr_data = rd_data;
      div_start = 1'b0;
      div_a = gstamp_ff - rd_data.stamp;
      div_b = {1'b0, rd_data.freq} + 33'd1;
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               idx_in = '0;
               match_v_in = 1'b0; empty_v_in = 1'b0; key_v_in = 1'b0;
               evict_in = 1'b0; flight_in = 1'b0;
               if (req_data.opcode == OP_LOOKUP || req_data.opcode == OP_FETCH)
                  ltotal_in = ltotal_ff + 64'd1;
               st_in = (req_data.opcode == OP_LOOKUP) ? S_AGE_CHK : S_SCAN_RD;
            end
         end
         // Aging for a lookup: halve frequencies of slots below high water.
         S_AGE_CHK: begin
            idx_in = '0;
            if (cfg.aging_period != 32'd0 && hw_ff != '0) begin
               div_start = 1'b1;
               div_a = ltotal_ff;
               div_b = {1'b0, cfg.aging_period};
               st_in = S_AGE_DIV;
            end else st_in = S_SCAN_RD;
         end
         S_AGE_DIV: begin
            if (div_done) st_in = (div_r == 33'd0) ? S_AGE_RD : S_SCAN_RD;
         end
         S_AGE_RD: st_in = S_AGE_WR;
         S_AGE_WR: begin
            wr_en = 1'b1;
            wr_data.freq = rd_data.freq >> 1;
            if (idx_ff + CW'(1) >= hw_ff) begin
               idx_in = '0; st_in = S_SCAN_RD;
            end else begin
               idx_in = idx_ff + CW'(1); st_in = S_AGE_RD;
            end
         end
         S_SCAN_RD: begin
            if (idx_ff >= CW'(SLOTS)) st_in = S_DECIDE;
            else st_in = S_SCAN;
         end
         S_SCAN: begin
            if (idx_ff < hw_ff && valid_ff[scan_idx] && key_eq) begin
               if (!key_v_ff) begin key_v_in = 1'b1; keym_in = scan_idx; end
               if (!match_v_ff &&
                   (size_eq || req_ff.opcode == OP_COMPLETE || req_ff.opcode == OP_INVAL)) begin
                  match_v_in = 1'b1; match_in = scan_idx;
               end
            end
            if (idx_ff < n_act && !valid_ff[scan_idx] && !empty_v_ff) begin
               empty_v_in = 1'b1; empty_in = scan_idx;
            end
            idx_in = idx_ff + CW'(1);
            st_in = S_SCAN_RD;
            rd_addr = IW'(idx_ff + CW'(1));
         end
         S_DECIDE: begin
            rd_addr = match_ff;
            case (req_ff.opcode)
               OP_COMPLETE, OP_INVAL: begin
                  if (!match_v_ff) begin
                     rsp_in = '{ST_ABSENT, 1'b0, 8'd0, 1'b0, 1'b0, pend_ff};
                     st_in = S_RESP;
                  end else begin
                     if (fly_ff[match_ff]) begin
                        fly_in[match_ff] = 1'b0;
                        if (pend_ff != 9'd0) pend_in = pend_ff - 9'd1;
                     end
                     if (req_ff.opcode == OP_INVAL) valid_in[match_ff] = 1'b0;
                     rsp_in = '{ST_OK, 1'b1, 8'(match_ff), req_ff.opcode == OP_COMPLETE,
                               1'b0, pend_in};
                     st_in = S_RESP;
                  end
               end
               OP_FETCH: begin
                  if (match_v_ff) st_in = S_TOUCH_RD;
                  else begin
                     flight_in = cfg.async_enable;
                     req_in.row_count = '0; req_in.col_count = '0;
                     if (!cfg.async_enable) st_in = S_AGE_CHK;  // acts as lookup
                     else st_in = empty_v_ff ? S_FILL : S_SAMP_RNG;
                     if (!cfg.async_enable) req_in.opcode = OP_LOOKUP;
                     if (!cfg.async_enable) begin
                        // rescan after aging; aging does not change keys
                        idx_in = '0;
                     end
                  end
               end
               default: begin
                  if (match_v_ff) st_in = S_TOUCH_RD;
                  else st_in = empty_v_ff ? S_FILL : S_SAMP_RNG;
               end
            endcase
            rng_in = gstamp_ff[31:0];
            samp_in = '0; found_in = 1'b0;
            if (st_in == S_SAMP_RNG && hw_ff == '0) begin
               rsp_in = '{ST_NOVICTIM, 1'b0, 8'd0, 1'b0, 1'b0, pend_ff};
               st_in = S_RESP;
            end
         end
         S_TOUCH_RD: begin
            rd_addr = match_ff;
            if (req_ff.opcode == OP_LOOKUP && dims_bad) begin
               // Dimension mismatch: drop the first key match of any size.
               if (fly_ff[keym_ff]) begin
                  fly_in[keym_ff] = 1'b0;
                  if (pend_ff != 9'd0) pend_in = pend_ff - 9'd1;
               end
               valid_in[keym_ff] = 1'b0;
               match_v_in = 1'b0;
               // An active dropped slot becomes the empty slot unless that is lower.
               if ((!empty_v_ff || keym_ff < empty_ff) && {1'b0, keym_ff} < n_act) begin
                  empty_v_in = 1'b1; empty_in = keym_ff;
               end
               st_in = empty_v_in ? S_FILL : S_SAMP_RNG;
               rng_in = gstamp_ff[31:0]; samp_in = '0; found_in = 1'b0;
            end else st_in = S_TOUCH_WR;
         end
         S_TOUCH_WR: begin
            wr_en = 1'b1; wr_addr = match_ff;
            gstamp_in = gstamp_ff + 64'd1;
            wr_data.stamp = gstamp_in;
            if (rd_data.freq != 32'hFFFF_FFFF) wr_data.freq = rd_data.freq + 32'd1;
            if (req_ff.opcode == OP_LOOKUP) begin
               if (fly_ff[match_ff]) begin
                  fly_in[match_ff] = 1'b0;
                  if (pend_ff != 9'd0) pend_in = pend_ff - 9'd1;
               end
               rsp_in = '{ST_OK, 1'b1, 8'(match_ff), 1'b1, 1'b0, pend_in};
            end else rsp_in = '{ST_OK, 1'b1, 8'(match_ff), !fly_ff[match_ff], 1'b0, pend_ff};
            st_in = S_RESP;
         end
         // Sampling: advance the generator, reduce modulo n in the divider.
         S_SAMP_RNG: begin
            if (samp_ff >= n_samp) st_in = S_VICTIM;
            else begin
               rng_in = rng_nx;
               div_start = 1'b1;
               div_a = {32'd0, rng_nx};
               div_b = {{(33-CW){1'b0}}, n_act};
               st_in = S_SAMP_SCORE;
            end
         end
         S_SAMP_SCORE: begin
            if (div_done) begin
               sidx_in = div_r[IW-1:0];
               rd_addr = div_r[IW-1:0];
               st_in = S_SAMP_RD;
            end
         end
         S_SAMP_RD: begin
            rd_addr = rng_idx;
            samp_in = samp_ff + SW'(1);
            if (!valid_ff[rng_idx] || fly_ff[rng_idx]) st_in = S_SAMP_RNG;
            else if (cfg.policy_mode == MODE_LRU) begin
               score_in = rd_data.stamp; st_in = S_SAMP_CMP;
            end else if (cfg.policy_mode == MODE_LFU) begin
               score_in = {32'd0, rd_data.freq}; st_in = S_SAMP_CMP;
            end else begin
               div_start = 1'b1; st_in = S_DIV;
            end
         end
         S_DIV: begin
            rd_addr = rng_idx;
            if (div_done) begin score_in = div_q; st_in = S_SAMP_CMP; end
         end
         S_SAMP_CMP: begin
            if (!found_ff ||
                (cfg.policy_mode <= MODE_LFU ? score_ff < best_ff : score_ff > best_ff)) begin
               found_in = 1'b1; best_in = score_ff; victim_in = rng_idx;
            end
            st_in = S_SAMP_RNG;
         end
         S_VICTIM: begin
            if (!found_ff) begin
               rsp_in = '{ST_NOVICTIM, 1'b0, 8'd0, 1'b0, 1'b0, pend_ff};
               st_in = S_RESP;
            end else begin
               if (fly_ff[victim_ff]) begin
                  fly_in[victim_ff] = 1'b0;
                  if (pend_ff != 9'd0) pend_in = pend_ff - 9'd1;
               end
               valid_in[victim_ff] = 1'b0;
               empty_v_in = 1'b1; empty_in = victim_ff; evict_in = 1'b1;
               st_in = S_FILL;
            end
         end
         S_FILL: begin
            wr_en = 1'b1; wr_addr = empty_ff;
            gstamp_in = gstamp_ff + 64'd1;
            wr_data = '{req_ff.tensor_key, req_ff.tensor_bytes, req_ff.row_count,
                        req_ff.col_count, gstamp_in, 32'd1};
            valid_in[empty_ff] = 1'b1;
            fly_in[empty_ff] = flight_ff;
            if (flight_ff) pend_in = pend_ff + 9'd1;
            if (hw_ff <= {1'b0, empty_ff}) hw_in = {1'b0, empty_ff} + CW'(1);
            rsp_in = '{ST_OK, 1'b0, 8'(empty_ff), !flight_ff, evict_ff, pend_in};
            st_in = S_RESP;
         end
         S_RESP: begin
            rspv_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; idx_ff <= idx_in; match_ff <= match_in; empty_ff <= empty_in;
      victim_ff <= victim_in; keym_ff <= keym_in; best_ff <= best_in;
      score_ff <= score_in; rng_ff <= rng_in; samp_ff <= samp_in; sidx_ff <= sidx_in;
      rsp_ff <= rsp_in; flight_ff <= flight_in; evict_ff <= evict_in;
      match_v_ff <= match_v_in; empty_v_ff <= empty_v_in; key_v_ff <= key_v_in;
      found_ff <= found_in;
      if (reset) begin
         st_ff <= S_IDLE; valid_ff <= '0; fly_ff <= '0; gstamp_ff <= 64'd1;
         ltotal_ff <= '0; hw_ff <= '0; pend_ff <= '0; rspv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; valid_ff <= valid_in; fly_ff <= fly_in; gstamp_ff <= gstamp_in;
         ltotal_ff <= ltotal_in; hw_ff <= hw_in; pend_ff <= pend_in;
         rspv_ff <= rspv_in;
      end
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

FILE: tb/sampled_eviction_cache_directory_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sampled_eviction_cache_directory_tb
// Drives lookups, fetches, completions and invalidations through the command
// port under several register settings, predicts each result with a local
// copy of the directory and checks every result strobe field by field.
// ----------------------------------------------------------------------------
module sampled_eviction_cache_directory_tb;
   import secd_pkg::*;

   localparam int SLOTS       = 256;
   localparam int MAX_SAMP    = 64;
   localparam int CYCLE_LIMIT = 40_000_000;
   localparam int TAIL_CYCLES = 6000;
   localparam int KEY_POOL    = 48;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sampled_eviction_cache_directory dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_psel(csr_psel),
      .csr_penable(csr_penable), .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // Local copy of the directory and its registers.
   bit          dir_valid [SLOTS];
   bit          dir_flight[SLOTS];
   logic [63:0] dir_key   [SLOTS];
   logic [63:0] dir_size  [SLOTS];
   logic [31:0] dir_rows  [SLOTS];
   logic [31:0] dir_cols  [SLOTS];
   logic [63:0] dir_stamp [SLOTS];
   logic [31:0] dir_freq  [SLOTS];
   logic [63:0] now_stamp;
   logic [63:0] lookup_count;
   int          high_water;
   int          fills_pending;

   logic [8:0]  cfg_entries;
   logic [1:0]  cfg_policy;
   logic [6:0]  cfg_samples;
   logic [31:0] cfg_aging;
   logic        cfg_async;

   rsp_type     expected_rsp[$];
   int          fail_count;
   int          cycle_count;
   bit          no_idle;

   logic [63:0] key_pool [KEY_POOL];
   logic [63:0] size_pool[3];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int active_slots();
      int n;
      n = cfg_entries;
      if (n < 1) n = 1;
      if (n > SLOTS) n = SLOTS;
      return n;
   endfunction

   function automatic int find_entry(logic [63:0] k, logic [63:0] sz, bit by_size);
      for (int i = 0; i < high_water && i < SLOTS; i++)
         if (dir_valid[i] && dir_key[i] == k && (!by_size || dir_size[i] == sz)) return i;
      return -1;
   endfunction

   function automatic void end_fill(int i);
      if (dir_flight[i]) begin
         dir_flight[i] = 1'b0;
         if (fills_pending > 0) fills_pending--;
      end
   endfunction

   function automatic void drop_entry(int i);
      end_fill(i);
      dir_valid[i] = 1'b0;
   endfunction

   function automatic void age_if_due();
      if (cfg_aging != 0 && (lookup_count % {32'd0, cfg_aging}) == 0)
         for (int i = 0; i < high_water && i < SLOTS; i++) dir_freq[i] = dir_freq[i] >> 1;
   endfunction

   function automatic void touch_entry(int i);
      now_stamp++;
      dir_stamp[i] = now_stamp;
      if (dir_freq[i] != 32'hFFFF_FFFF) dir_freq[i]++;
   endfunction

   // Xorshift sampling seeded from the stamp; in-flight and empty samples are skipped.
   function automatic int choose_victim();
      logic [31:0] rng;
      logic [31:0] n;
      logic [63:0] best;
      logic [63:0] score;
      int          samples;
      int          idx;
      int          victim;
      bit          found;
      bit          better;
      rng = now_stamp[31:0];
      n = active_slots();
      samples = (cfg_samples > MAX_SAMP) ? MAX_SAMP : cfg_samples;
      best = '0;
      victim = -1;
      found = 1'b0;
      if (high_water == 0) return -1;
      for (int s = 0; s < samples; s++) begin
         rng = rng ^ (rng << 13);
         rng = rng ^ (rng >> 17);
         rng = rng ^ (rng << 5);
         idx = int'(rng % n);
         if (!dir_valid[idx] || dir_flight[idx]) continue;
         if (cfg_policy == MODE_LRU) score = dir_stamp[idx];
         else if (cfg_policy == MODE_LFU) score = {32'd0, dir_freq[idx]};
         else score = (now_stamp - dir_stamp[idx]) / ({32'd0, dir_freq[idx]} + 64'd1);
         if (cfg_policy == MODE_LRU || cfg_policy == MODE_LFU) better = !found || score < best;
         else better = !found || score > best;
         if (better) begin
            found = 1'b1;
            best = score;
            victim = idx;
         end
      end
      return victim;
   endfunction

   function automatic rsp_type fill_miss(req_type r, logic [31:0] rows, logic [31:0] cols,
                                         bit flight);
      rsp_type o;
      int      s;
      bit      ev;
      o = '0;
      s = -1;
      ev = 1'b0;
      for (int i = 0; i < active_slots(); i++)
         if (!dir_valid[i]) begin
            s = i;
            break;
         end
      if (s < 0) begin
         s = choose_victim();
         if (s < 0) begin
            o.status = ST_NOVICTIM;
            return o;
         end
         drop_entry(s);
         ev = 1'b1;
      end
      dir_key[s] = r.tensor_key;
      dir_size[s] = r.tensor_bytes;
      dir_rows[s] = rows;
      dir_cols[s] = cols;
      now_stamp++;
      dir_stamp[s] = now_stamp;
      dir_freq[s] = 32'd1;
      dir_valid[s] = 1'b1;
      dir_flight[s] = flight;
      if (flight) fills_pending++;
      if (high_water <= s) high_water = s + 1;
      o.status = ST_OK;
      o.slot = s[7:0];
      o.ready_res = !flight;
      o.evicted = ev;
      return o;
   endfunction

   function automatic rsp_type predict_directory(req_type r);
      rsp_type o;
      int      idx;
      int      j;
      o = '0;
      case (r.opcode)
         OP_LOOKUP: begin
            lookup_count++;
            age_if_due();
            idx = find_entry(r.tensor_key, r.tensor_bytes, 1'b1);
            if (idx >= 0 && r.row_count != 0 && r.col_count != 0 &&
                (dir_rows[idx] != r.row_count || dir_cols[idx] != r.col_count)) begin
               // Dimension mismatch drops the first entry with this key, of any size.
               j = find_entry(r.tensor_key, '0, 1'b0);
               if (j >= 0) drop_entry(j);
               idx = -1;
            end
            if (idx >= 0) begin
               touch_entry(idx);
               end_fill(idx);
               o.status = ST_OK;
               o.hit = 1'b1;
               o.slot = idx[7:0];
               o.ready_res = 1'b1;
            end else begin
               o = fill_miss(r, r.row_count, r.col_count, 1'b0);
            end
         end
         OP_FETCH: begin
            lookup_count++;
            idx = find_entry(r.tensor_key, r.tensor_bytes, 1'b1);
            if (idx >= 0) begin
               touch_entry(idx);
               o.status = ST_OK;
               o.hit = 1'b1;
               o.slot = idx[7:0];
               o.ready_res = !dir_flight[idx];
            end else if (!cfg_async) begin
               age_if_due();
               o = fill_miss(r, '0, '0, 1'b0);
            end else begin
               o = fill_miss(r, '0, '0, 1'b1);
            end
         end
         default: begin
            idx = find_entry(r.tensor_key, '0, 1'b0);
            if (idx < 0) begin
               o.status = ST_ABSENT;
            end else begin
               if (r.opcode == OP_COMPLETE) end_fill(idx);
               else drop_entry(idx);
               o.status = ST_OK;
               o.hit = 1'b1;
               o.slot = idx[7:0];
               o.ready_res = (r.opcode == OP_COMPLETE);
            end
         end
      endcase
      o.pending_transfers = fills_pending[8:0];
      return o;
   endfunction

   task automatic send_item(logic [1:0] op, logic [63:0] k, logic [63:0] sz,
                            logic [31:0] rows, logic [31:0] cols);
      req_type r;
      r.opcode = op;
      r.tensor_key = k;
      r.tensor_bytes = sz;
      r.row_count = rows;
      r.col_count = cols;
      if (!no_idle && $urandom_range(0, 99) < 28) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      expected_rsp.push_back(predict_directory(r));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(logic [8:0] entries, logic [1:0] policy, logic [6:0] samples,
                             logic [31:0] aging, logic async_on);
      wait_drained();
      csr_write(REG_ENTRIES, {23'd0, entries});
      csr_write(REG_POLICY, {30'd0, policy});
      csr_write(REG_SAMPLES, {25'd0, samples});
      csr_write(REG_AGING, aging);
      csr_write(REG_ASYNC, {31'd0, async_on});
      cfg_entries = entries;
      cfg_policy = policy;
      cfg_samples = samples;
      cfg_aging = aging;
      cfg_async = async_on;
   endtask

   task automatic test_basic_ops();
      logic [63:0] a;
      logic [63:0] b;
      a = 64'h0123_4567_89AB_CDEF;
      b = 64'hFEDC_BA98_7654_3210;
      send_item(OP_LOOKUP, a, 64'd4096, 32'd8, 32'd16);       // miss fill
      send_item(OP_LOOKUP, a, 64'd4096, 32'd8, 32'd16);       // hit with matching dims
      send_item(OP_LOOKUP, a, 64'd4096, 32'd0, 32'd16);       // check skipped
      send_item(OP_LOOKUP, a, 64'd4096, 32'd9, 32'd16);       // mismatch drops and refills
      send_item(OP_FETCH, b, 64'd0, 32'd0, 32'd0);            // async miss, in flight
      send_item(OP_FETCH, b, 64'd0, 32'd1, 32'd1);            // hit while still in flight
      send_item(OP_COMPLETE, b, 64'd77, 32'd0, 32'd0);        // completion ignores size
      send_item(OP_FETCH, b, 64'd0, 32'd0, 32'd0);
      send_item(OP_INVAL, a, 64'd1, 32'd0, 32'd0);
      send_item(OP_INVAL, a, 64'd1, 32'd0, 32'd0);            // now absent
      send_item(OP_COMPLETE, 64'd5, 64'd5, 32'd0, 32'd0);     // absent
      send_item(OP_LOOKUP, '0, '0, '1, '1);
      send_item(OP_LOOKUP, '1, '1, '1, '1);
      send_item(OP_LOOKUP, '1, '1, 32'hFFFF_FFFE, '1);        // mismatch on extreme entry
      send_item(OP_FETCH, '1, '0, '0, '0);
      send_item(OP_LOOKUP, '1, '0, 32'd3, 32'd4);             // mismatch drops the first entry of this key
   endtask

   task automatic test_no_victim();
      // One slot, no samples: a miss on a full directory finds no victim.
      set_config(9'd1, MODE_LRU, 7'd0, 32'd0, 1'b1);
      send_item(OP_LOOKUP, 64'd11, 64'd1, 32'd0, 32'd0);
      set_config(9'd1, MODE_LRU, 7'd4, 32'd0, 1'b1);
      send_item(OP_LOOKUP, 64'd12, 64'd1, 32'd0, 32'd0);      // evicts slot zero
      send_item(OP_INVAL, 64'd12, 64'd1, 32'd0, 32'd0);
      send_item(OP_FETCH, 64'd13, 64'd2, 32'd0, 32'd0);
      send_item(OP_LOOKUP, 64'd14, 64'd2, 32'd0, 32'd0);      // only sample is in flight
      send_item(OP_COMPLETE, 64'd13, 64'd2, 32'd0, 32'd0);
      send_item(OP_FETCH, 64'd15, 64'd2, 32'd0, 32'd0);       // evicts completed entry
   endtask

   task automatic random_items(int count);
      int          span;
      int          pick;
      logic [1:0]  op;
      logic [63:0] k;
      logic [63:0] sz;
      logic [31:0] rows;
      logic [31:0] cols;
      span = 2 * active_slots() + 2;
      if (span > KEY_POOL) span = KEY_POOL;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         op = (pick < 40) ? OP_LOOKUP : (pick < 70) ? OP_FETCH :
              (pick < 85) ? OP_COMPLETE : OP_INVAL;
         k = key_pool[$urandom_range(0, span - 1)];
         sz = size_pool[$urandom_range(0, 2)];
         if ($urandom_range(0, 99) < 8) begin
            k = {$urandom, $urandom};
            sz = {$urandom, $urandom};
         end
         rows = '0;
         cols = '0;
         if ($urandom_range(0, 1) == 1) begin
            rows = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
            cols = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
         end
         send_item(op, k, sz, rows, cols);
      end
   endtask

   task automatic test_random_traffic();
      set_config(9'd8, MODE_LRU, 7'd4, 32'd0, 1'b1);
      random_items(75);
      set_config(9'd8, MODE_LFU, 7'd8, 32'd3, 1'b1);
      random_items(75);
      set_config(9'd16, 2'd2, 7'd16, 32'd1, 1'b0);
      no_idle = 1'b1;
      random_items(75);
      no_idle = 1'b0;
      set_config(9'd4, 2'd3, 7'd64, 32'hFFFF_FFFF, 1'b1);
      random_items(75);
      set_config(9'd256, 2'd2, 7'd127, 32'd65536, 1'b1);
      random_items(75);
      set_config(9'd0, MODE_LRU, 7'd1, 32'd2, 1'b1);
      random_items(40);
      wait_drained();                       // let every result arrive mid-phase
      random_items(35);
      set_config(9'd511, MODE_LFU, 7'd0, 32'd0, 1'b0);
      random_items(75);
      set_config(9'd12, 2'd2, 7'd6, 32'd5, 1'b1);
      random_items(75);
      set_config(9'd6, MODE_LRU, 7'd64, 32'd7, 1'b0);
      random_items(75);
      set_config(9'd24, 2'd2, 7'd32, 32'd0, 1'b1);
      random_items(75);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[sampled_eviction_cache_directory] ERROR");
            $finish;
         end
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result transfer");
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.hit !== want.hit) begin
                  $error("hit expected %0d got %0d", want.hit, rsp_data.hit);
                  fail_count++;
               end
               if (rsp_data.slot !== want.slot) begin
                  $error("slot expected %0d got %0d", want.slot, rsp_data.slot);
                  fail_count++;
               end
               if (rsp_data.ready_res !== want.ready_res) begin
                  $error("ready_res expected %0d got %0d", want.ready_res, rsp_data.ready_res);
                  fail_count++;
               end
               if (rsp_data.evicted !== want.evicted) begin
                  $error("evicted expected %0d got %0d", want.evicted, rsp_data.evicted);
                  fail_count++;
               end
               if (rsp_data.pending_transfers !== want.pending_transfers) begin
                  $error("pending_transfers expected %0d got %0d", want.pending_transfers,
                         rsp_data.pending_transfers);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      fail_count = 0;
      cycle_count = 0;
      no_idle = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         dir_valid[i] = 1'b0;
         dir_flight[i] = 1'b0;
      end
      now_stamp = 64'd1;
      lookup_count = '0;
      high_water = 0;
      fills_pending = 0;
      cfg_entries = 9'd256;
      cfg_policy = 2'd2;
      cfg_samples = 7'd16;
      cfg_aging = 32'd65536;
      cfg_async = 1'b1;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
      size_pool[0] = '0;
      size_pool[1] = '1;
      size_pool[2] = {$urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_no_victim();
      test_random_traffic();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("[sampled_eviction_cache_directory] OK");
      end else begin
         $display("[sampled_eviction_cache_directory] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/secd_pkg.sv
src/secd_divider.sv
src/secd_csr.sv
src/sampled_eviction_cache_directory.sv
tb/sampled_eviction_cache_directory_tb.sv
